FILE: rtl/tmpe_pkg.sv
// ----------------------------------------------------------------------------
// tmpe_pkg
// Shared types and constants of the transfer-matrix polynomial evaluator.
// ----------------------------------------------------------------------------
package tmpe_pkg;

    localparam int COEF_W    = 48;
    localparam int DATA_W    = 32;
    localparam int BREF_W    = 32;
    localparam int ORDER_W   = 3;
    localparam int POW_W     = 3;
    localparam int NUM_POLY  = 4;
    localparam int ADDR_W    = 4 * POW_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DATA_FRAC = 28;
    localparam int REF_FRAC  = 24;
    localparam int SUM_W     = 5;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd7;
    localparam logic [BREF_W-1:0]  BREF_RESET  = 32'h0100_0000;
    localparam logic [DATA_W-1:0]  MONO_ONE    = 32'h1000_0000;

    // configuration register indexes
    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_BREF  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;

    localparam logic MODE_LOAD = 1'b0;

    localparam int POLY_PHI = 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_P0,
        S_P1,
        S_DRAIN,
        S_SCALE,
        S_SWAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_L,
        STEP_K,
        STEP_J,
        STEP_I,
        STEP_END
    } t_step;

    typedef struct packed {
        logic valid;
        logic acc;
        logic ref_scale;
        logic clear;
    } t_lane_ctl;

endpackage

FILE: rtl/transfer_matrix_poly_eval_core.sv
// ----------------------------------------------------------------------------
// transfer_matrix_poly_eval_core
// Four-polynomial transfer-matrix evaluator with a coefficient store.
// ----------------------------------------------------------------------------
// After reset the coefficient store (four RAMs of 4096 entries) is cleared,
// during which no item is taken; configuration writes are taken at any
// time. A load item writes one coefficient if the order is nonzero and its
// powers are within poly_order. A reconstruct item walks all power sets of
// total degree up to poly_order (330 terms at order 7): the monomial update
// runs through one 32x32 multiplier and a rounding stage, and all four
// coefficient RAMs are read in parallel for the same term. After the last
// term the lanes drain, lane 0 scales its sum by the brho reference, the
// scaled brho is awaited and the result goes to the output register, which
// may stall; no new item is taken until the result has been handed over.
module transfer_matrix_poly_eval_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [tmpe_pkg::BREF_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic [1:0]                           i_coef_select,
    input  logic [tmpe_pkg::POW_W-1:0]           i_pow_x,
    input  logic [tmpe_pkg::POW_W-1:0]           i_pow_y,
    input  logic [tmpe_pkg::POW_W-1:0]           i_pow_t,
    input  logic [tmpe_pkg::POW_W-1:0]           i_pow_p,
    input  logic signed [tmpe_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [tmpe_pkg::DATA_W-1:0]   i_x_pos,
    input  logic signed [tmpe_pkg::DATA_W-1:0]   i_y_pos,
    input  logic signed [tmpe_pkg::DATA_W-1:0]   i_theta_in,
    input  logic signed [tmpe_pkg::DATA_W-1:0]   i_phi_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic signed [tmpe_pkg::COEF_W-1:0]   o_brho,
    output logic signed [tmpe_pkg::COEF_W-1:0]   o_theta_mrad,
    output logic signed [tmpe_pkg::COEF_W-1:0]   o_phi_mrad,
    output logic signed [tmpe_pkg::COEF_W-1:0]   o_path_cm
);

    localparam int CW = tmpe_pkg::COEF_W;
    localparam int DW = tmpe_pkg::DATA_W;
    localparam int PW = tmpe_pkg::POW_W;
    localparam int AW = tmpe_pkg::ADDR_W;
    localparam int NP = tmpe_pkg::NUM_POLY;
    localparam int SW = tmpe_pkg::SUM_W;
    localparam int MW = 2 * DW;
    localparam logic [MW:0] M_HI = (MW+1)'({1'b0, {(DW-1){1'b1}}});
    localparam logic [MW:0] M_LO = (MW+1)'({1'b1, {(DW-1){1'b0}}});

    tmpe_pkg::t_state r_state, n_state;

    logic [tmpe_pkg::ORDER_W-1:0] r_order;
    logic [tmpe_pkg::BREF_W-1:0]  r_bref;
    logic [AW-1:0]                r_cnt;

    logic [PW-1:0] r_i, r_j, r_k, r_l;
    logic signed [DW-1:0] r_x, r_y, r_t, r_p;
    logic signed [DW-1:0] r_mi, r_mij, r_mijk, r_mono;
    logic [MW-1:0] r_mprod;
    logic          r_mneg;
    logic signed [CW-1:0] r_bsum;

    logic          r_ovalid;
    logic [1:0]    r_status;
    logic signed [CW-1:0] r_obrho, r_otheta, r_ophi, r_opath;

    logic w_accept, w_out_free, w_ord_zero, w_in_range;
    logic [SW-1:0] w_sum;
    tmpe_pkg::t_step w_step;
    logic signed [DW-1:0] w_base, w_var, w_mval;
    logic [DW:0]   w_base_abs, w_var_abs;
    logic [MW:0]   w_mrnd, w_mmag;

    logic          w_ram_we [NP];
    logic [AW-1:0] w_ram_addr;
    logic [CW-1:0] w_ram_wdata;
    logic [CW-1:0] w_ram_rdata [NP];

    tmpe_pkg::t_lane_ctl  w_lane_ctl [NP];
    logic signed [CW-1:0] w_lane_a [NP];
    logic signed [DW:0]   w_lane_b [NP];
    logic signed [CW-1:0] w_lane_term [NP];
    logic                 w_lane_tv [NP];
    logic signed [CW-1:0] w_lane_acc [NP];

    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == tmpe_pkg::S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ord_zero = (r_order == '0);
    assign w_in_range = (i_pow_x <= r_order) && (i_pow_y <= r_order) &&
                        (i_pow_t <= r_order) && (i_pow_p <= r_order);

    // next power set and the monomial factor that it needs
    assign w_sum = SW'(r_i) + SW'(r_j) + SW'(r_k) + SW'(r_l);

    always_comb begin
        priority if (w_sum < SW'(r_order)) begin
            w_step = tmpe_pkg::STEP_L;
            w_base = r_mono;
            w_var  = r_p;
        end else if (r_l != '0) begin
            w_step = tmpe_pkg::STEP_K;
            w_base = r_mijk;
            w_var  = r_t;
        end else if (r_k != '0) begin
            w_step = tmpe_pkg::STEP_J;
            w_base = r_mij;
            w_var  = r_y;
        end else if (r_j != '0) begin
            w_step = tmpe_pkg::STEP_I;
            w_base = r_mi;
            w_var  = r_x;
        end else begin
            w_step = tmpe_pkg::STEP_END;
            w_base = r_mono;
            w_var  = r_p;
        end
    end

    assign w_base_abs = w_base[DW-1] ? ((DW+1)'(0) - {w_base[DW-1], w_base})
                                     : {1'b0, w_base};
    assign w_var_abs  = w_var[DW-1]  ? ((DW+1)'(0) - {w_var[DW-1], w_var})
                                     : {1'b0, w_var};

    always_comb begin
        w_mrnd = {1'b0, r_mprod} + ((MW+1)'(1) << (tmpe_pkg::DATA_FRAC - 1));
        w_mmag = w_mrnd >> tmpe_pkg::DATA_FRAC;
        if (r_mneg) begin
            w_mval = (w_mmag > M_LO) ? {1'b1, {(DW-1){1'b0}}}
                                     : DW'((MW+1)'(0) - w_mmag);
        end else begin
            w_mval = (w_mmag > M_HI) ? {1'b0, {(DW-1){1'b1}}} : DW'(w_mmag);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmpe_pkg::S_CLEAR: begin
                if (r_cnt == '1) begin
                    n_state = tmpe_pkg::S_IDLE;
                end
            end
            tmpe_pkg::S_IDLE: begin
                if (w_accept && !w_ord_zero && i_mode != tmpe_pkg::MODE_LOAD) begin
                    n_state = tmpe_pkg::S_P0;
                end
            end
            tmpe_pkg::S_P0: n_state = tmpe_pkg::S_P1;
            tmpe_pkg::S_P1: begin
                n_state = (w_step == tmpe_pkg::STEP_END) ? tmpe_pkg::S_DRAIN
                                                         : tmpe_pkg::S_P0;
            end
            tmpe_pkg::S_DRAIN: begin
                if (r_cnt == AW'(2)) begin
                    n_state = tmpe_pkg::S_SCALE;
                end
            end
            tmpe_pkg::S_SCALE: n_state = tmpe_pkg::S_SWAIT;
            tmpe_pkg::S_SWAIT: begin
                if (w_lane_tv[0]) begin
                    n_state = tmpe_pkg::S_OUT;
                end
            end
            tmpe_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = tmpe_pkg::S_IDLE;
                end
            end
            default: n_state = tmpe_pkg::S_IDLE;
        endcase
    end

    // memory and lane controls
    always_comb begin
        w_ram_addr  = {r_i, r_j, r_k, r_l};
        w_ram_wdata = i_coef_value;
        for (int p = 0; p < NP; p++) begin
            w_ram_we[p]   = 1'b0;
            w_lane_ctl[p] = '0;
            w_lane_a[p]   = w_ram_rdata[p];
            if (p == tmpe_pkg::POLY_PHI) begin
                w_lane_b[p] = {r_mono[DW-1], r_mono};
            end else if (r_j == '0 && r_l == '0) begin
                w_lane_b[p] = {r_mono[DW-1], r_mono};
            end else begin
                w_lane_b[p] = '0;
            end
        end
        unique case (r_state)
            tmpe_pkg::S_CLEAR: begin
                w_ram_addr  = r_cnt;
                w_ram_wdata = '0;
                for (int p = 0; p < NP; p++) begin
                    w_ram_we[p] = 1'b1;
                end
            end
            tmpe_pkg::S_IDLE: begin
                w_ram_addr = {i_pow_x, i_pow_y, i_pow_t, i_pow_p};
                for (int p = 0; p < NP; p++) begin
                    w_ram_we[p] = w_accept && !w_ord_zero && w_in_range &&
                                  (i_mode == tmpe_pkg::MODE_LOAD) &&
                                  (i_coef_select == 2'(p));
                    w_lane_ctl[p].clear = w_accept;
                end
            end
            tmpe_pkg::S_P1: begin
                for (int p = 0; p < NP; p++) begin
                    w_lane_ctl[p].valid = 1'b1;
                    w_lane_ctl[p].acc   = 1'b1;
                end
            end
            tmpe_pkg::S_SCALE: begin
                w_lane_ctl[0].valid     = 1'b1;
                w_lane_ctl[0].ref_scale = 1'b1;
                w_lane_a[0]             = w_lane_acc[0];
                w_lane_b[0]             = {1'b0, r_bref};
            end
            tmpe_pkg::S_P0, tmpe_pkg::S_DRAIN, tmpe_pkg::S_SWAIT,
            tmpe_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmpe_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_order  <= tmpe_pkg::ORDER_RESET;
            r_bref   <= tmpe_pkg::BREF_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == tmpe_pkg::CFG_ORDER) begin
                    r_order <= i_cfg_data[tmpe_pkg::ORDER_W-1:0];
                end else begin
                    r_bref <= i_cfg_data;
                end
            end
            if (r_state == tmpe_pkg::S_CLEAR || r_state == tmpe_pkg::S_DRAIN) begin
                r_cnt <= (n_state == r_state) ? r_cnt + AW'(1) : '0;
            end
            if ((w_accept && (w_ord_zero || i_mode == tmpe_pkg::MODE_LOAD)) ||
                (r_state == tmpe_pkg::S_OUT && w_out_free)) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload: point, monomial chain, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
            r_t    <= i_theta_in;
            r_p    <= i_phi_in;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_l    <= '0;
            r_mi   <= tmpe_pkg::MONO_ONE;
            r_mij  <= tmpe_pkg::MONO_ONE;
            r_mijk <= tmpe_pkg::MONO_ONE;
            r_mono <= tmpe_pkg::MONO_ONE;
        end
        if (r_state == tmpe_pkg::S_P0) begin
            r_mprod <= MW'(w_base_abs[DW-1:0] * w_var_abs[DW-1:0]);
            r_mneg  <= w_base[DW-1] ^ w_var[DW-1];
        end
        if (r_state == tmpe_pkg::S_P1) begin
            unique case (w_step)
                tmpe_pkg::STEP_L: begin
                    r_mono <= w_mval;
                    r_l    <= r_l + PW'(1);
                end
                tmpe_pkg::STEP_K: begin
                    r_mijk <= w_mval;
                    r_mono <= w_mval;
                    r_k    <= r_k + PW'(1);
                    r_l    <= '0;
                end
                tmpe_pkg::STEP_J: begin
                    r_mij  <= w_mval;
                    r_mijk <= w_mval;
                    r_mono <= w_mval;
                    r_j    <= r_j + PW'(1);
                    r_k    <= '0;
                    r_l    <= '0;
                end
                tmpe_pkg::STEP_I: begin
                    r_mi   <= w_mval;
                    r_mij  <= w_mval;
                    r_mijk <= w_mval;
                    r_mono <= w_mval;
                    r_i    <= r_i + PW'(1);
                    r_j    <= '0;
                    r_k    <= '0;
                    r_l    <= '0;
                end
                tmpe_pkg::STEP_END: begin
                end
                default: begin
                end
            endcase
        end
        if (r_state == tmpe_pkg::S_SWAIT && w_lane_tv[0]) begin
            r_bsum <= w_lane_term[0];
        end
        if (w_accept && (w_ord_zero || i_mode == tmpe_pkg::MODE_LOAD)) begin
            if (w_ord_zero) begin
                r_status <= tmpe_pkg::ST_NOT_READY;
            end else if (!w_in_range) begin
                r_status <= tmpe_pkg::ST_IGNORED;
            end else begin
                r_status <= tmpe_pkg::ST_DONE;
            end
            r_obrho  <= '0;
            r_otheta <= '0;
            r_ophi   <= '0;
            r_opath  <= '0;
        end else if (r_state == tmpe_pkg::S_OUT && w_out_free) begin
            r_status <= tmpe_pkg::ST_DONE;
            r_obrho  <= r_bsum;
            r_otheta <= w_lane_acc[1];
            r_ophi   <= w_lane_acc[2];
            r_opath  <= w_lane_acc[3];
        end
    end

    for (genvar p = 0; p < NP; p++) begin : g_poly
        tmpe_ram #(
            .WIDTH (CW),
            .DEPTH (tmpe_pkg::RAM_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_ram_we[p]),
            .i_addr  (w_ram_addr),
            .i_wdata (w_ram_wdata),
            .o_rdata (w_ram_rdata[p])
        );

        tmpe_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_lane_ctl[p]),
            .i_a          (w_lane_a[p]),
            .i_b          (w_lane_b[p]),
            .o_term       (w_lane_term[p]),
            .o_term_valid (w_lane_tv[p]),
            .o_acc        (w_lane_acc[p])
        );
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_brho       = r_obrho;
    assign o_theta_mrad = r_otheta;
    assign o_phi_mrad   = r_ophi;
    assign o_path_cm    = r_opath;

endmodule

FILE: rtl/tmpe_ram.sv
// ----------------------------------------------------------------------------
// tmpe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tmpe_lane.sv
// ----------------------------------------------------------------------------
// tmpe_lane
// One polynomial lane: coefficient times monomial with rounding and
// saturation, followed by a saturating accumulator.
// ----------------------------------------------------------------------------
module tmpe_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tmpe_pkg::t_lane_ctl                i_ctl,
    input  logic signed [tmpe_pkg::COEF_W-1:0] i_a,
    input  logic signed [tmpe_pkg::DATA_W:0]   i_b,
    output logic signed [tmpe_pkg::COEF_W-1:0] o_term,
    output logic                               o_term_valid,
    output logic signed [tmpe_pkg::COEF_W-1:0] o_acc
);

    localparam int AW   = tmpe_pkg::COEF_W;
    localparam int BW   = tmpe_pkg::DATA_W;
    localparam int HW   = AW / 2;
    localparam int PW   = HW + BW;
    localparam int FW   = AW + BW;
    localparam logic [FW-1:0] MAG_HI = FW'({1'b0, {(AW-1){1'b1}}});
    localparam logic [FW-1:0] MAG_LO = FW'({1'b1, {(AW-1){1'b0}}});

    // stage A
    logic          r_va, r_acca, r_sha, r_nega;
    logic [AW-1:0] r_ua;
    logic [BW-1:0] r_ub;
    // stage B
    logic          r_vb, r_accb, r_shb, r_negb;
    logic [PW-1:0] r_plo, r_phi;
    // stage C
    logic          r_vc, r_accc;
    logic signed [AW-1:0] r_term;
    // stage D
    logic signed [AW-1:0] r_acc;

    logic [AW:0]   w_ua;
    logic [BW:0]   w_ub;
    logic [FW-1:0] w_prod, w_rnd, w_mag;
    logic signed [AW-1:0] w_term;
    logic signed [AW:0]   w_sum;

    assign w_ua = i_a[AW-1] ? ((AW+1)'(0) - {i_a[AW-1], i_a}) : {1'b0, i_a};
    assign w_ub = i_b[BW]   ? ((BW+1)'(0) - i_b) : i_b;

    always_comb begin
        w_prod = {r_phi, {HW{1'b0}}} + {{(FW-PW){1'b0}}, r_plo};
        if (r_shb) begin
            w_rnd = w_prod + (FW'(1) << (tmpe_pkg::REF_FRAC - 1));
            w_mag = w_rnd >> tmpe_pkg::REF_FRAC;
        end else begin
            w_rnd = w_prod + (FW'(1) << (tmpe_pkg::DATA_FRAC - 1));
            w_mag = w_rnd >> tmpe_pkg::DATA_FRAC;
        end
        if (r_negb) begin
            w_term = (w_mag > MAG_LO) ? {1'b1, {(AW-1){1'b0}}}
                                      : AW'(FW'(0) - w_mag);
        end else begin
            w_term = (w_mag > MAG_HI) ? {1'b0, {(AW-1){1'b1}}} : AW'(w_mag);
        end
    end

    always_comb begin
        w_sum = {r_acc[AW-1], r_acc} + {r_term[AW-1], r_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_ctl.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acca <= i_ctl.acc;
        r_sha  <= i_ctl.ref_scale;
        r_nega <= i_a[AW-1] ^ i_b[BW];
        r_ua   <= w_ua[AW-1:0];
        r_ub   <= w_ub[BW-1:0];

        r_accb <= r_acca;
        r_shb  <= r_sha;
        r_negb <= r_nega;
        r_plo  <= PW'(r_ua[HW-1:0] * r_ub);
        r_phi  <= PW'(r_ua[AW-1:HW] * r_ub);

        r_accc <= r_accb;
        r_term <= w_term;

        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_vc && r_accc) begin
            // saturate on overflow of the sign bit
            if (w_sum[AW] != w_sum[AW-1]) begin
                r_acc <= w_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end else begin
                r_acc <= w_sum[AW-1:0];
            end
        end
    end

    assign o_term       = r_term;
    assign o_term_valid = r_vc;
    assign o_acc        = r_acc;

endmodule

FILE: dv/tb_transfer_matrix_poly_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transfer_matrix_poly_eval_core
// Self-checking bench for the four-polynomial transfer-matrix evaluator.
// Coefficient loads and trajectory reconstructions are driven over a
// valid/ready channel with random bursts and gaps. A bit-exact predictor
// keeps its own coefficient store and expects one result per item, checked
// field by field against a stalling result channel. Order and brho reference
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_transfer_matrix_poly_eval_core;
    import tmpe_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  STORE_SIZE  = NUM_POLY * RAM_DEPTH;
    localparam logic MODE_RECON = 1'b1;

    typedef struct {
        logic                     mode;
        logic [1:0]               sel;
        logic [POW_W-1:0]         px, py, pt, pp;
        logic signed [COEF_W-1:0] coef;
        logic signed [DATA_W-1:0] x, y, t, p;
    } traj_item_t;

    typedef struct {
        logic [1:0]               status;
        logic signed [COEF_W-1:0] brho, theta, phi, path;
    } traj_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_index = CFG_ORDER;
    logic [BREF_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_mode = MODE_LOAD;
    logic [1:0]               i_coef_select = '0;
    logic [POW_W-1:0]         i_pow_x = '0, i_pow_y = '0, i_pow_t = '0, i_pow_p = '0;
    logic signed [COEF_W-1:0] i_coef_value = '0;
    logic signed [DATA_W-1:0] i_x_pos = '0, i_y_pos = '0, i_theta_in = '0, i_phi_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic signed [COEF_W-1:0] o_brho, o_theta_mrad, o_phi_mrad, o_path_cm;

    transfer_matrix_poly_eval_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_coef_select (i_coef_select),
        .i_pow_x       (i_pow_x),
        .i_pow_y       (i_pow_y),
        .i_pow_t       (i_pow_t),
        .i_pow_p       (i_pow_p),
        .i_coef_value  (i_coef_value),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_theta_in    (i_theta_in),
        .i_phi_in      (i_phi_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_brho        (o_brho),
        .o_theta_mrad  (o_theta_mrad),
        .o_phi_mrad    (o_phi_mrad),
        .o_path_cm     (o_path_cm)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // predictor state
    longint            coef_mem [STORE_SIZE];
    int unsigned       cur_order;
    longint            cur_bref;

    traj_item_t        pending_items[$];
    traj_result_t      expected_results[$];
    traj_item_t        drv_item;
    int                burst_left = 0;
    int                gap_left = 0;
    bit                sender_gaps = 1'b0;
    int                stall_style = 0;
    int                mismatches = 0;
    longint            cycle_count = 0;

    localparam longint COEF_HI = (64'sd1 <<< (COEF_W - 1)) - 1;
    localparam longint COEF_LO = -(64'sd1 <<< (COEF_W - 1));
    localparam longint DATA_HI = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint DATA_LO = -(64'sd1 <<< (DATA_W - 1));

    // round(a*b / 2^sh) half away from zero, then clamp
    function automatic longint mul_round_sat(longint a, longint b, int sh,
                                             longint lo, longint hi);
        logic signed [127:0] pa, pb, prod;
        logic [127:0]        mag;
        logic                neg;
        pa   = a;
        pb   = b;
        prod = pa * pb;
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + (128'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (mag > 128'(-lo)) return lo;
            return -longint'(mag);
        end
        if (mag > 128'(hi)) return hi;
        return longint'(mag);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > COEF_HI) return COEF_HI;
        if (s < COEF_LO) return COEF_LO;
        return s;
    endfunction

    function automatic longint raise_pow(longint m, longint v, int e);
        for (int n = 0; n < e; n++)
            m = mul_round_sat(m, v, DATA_FRAC, DATA_LO, DATA_HI);
        return m;
    endfunction

    function automatic int store_addr(int sel, int i, int j, int k, int l);
        return (((sel * 8 + i) * 8 + j) * 8 + k) * 8 + l;
    endfunction

    function automatic traj_result_t predict_result(traj_item_t it);
        traj_result_t r;
        longint       sum [4];
        longint       mp, ma, c, unit;
        int           ord;
        r     = '{status: ST_DONE, brho: '0, theta: '0, phi: '0, path: '0};
        ord   = cur_order;
        unit  = longint'(MONO_ONE);
        if (ord == 0) begin
            r.status = ST_NOT_READY;
            return r;
        end
        if (it.mode == MODE_LOAD) begin
            if (it.px > ord || it.py > ord || it.pt > ord || it.pp > ord)
                r.status = ST_IGNORED;
            else
                coef_mem[store_addr(it.sel, it.px, it.py, it.pt, it.pp)] = it.coef;
            return r;
        end
        for (int p = 0; p < 4; p++) sum[p] = 0;
        for (int i = 0; i <= ord; i++)
            for (int j = 0; i + j <= ord; j++)
                for (int k = 0; i + j + k <= ord; k++)
                    for (int l = 0; i + j + k + l <= ord; l++) begin
                        mp = raise_pow(raise_pow(raise_pow(raise_pow(unit, it.x, i),
                             it.y, j), it.t, k), it.p, l);
                        ma = (j == 0 && l == 0) ?
                             raise_pow(raise_pow(unit, it.x, i), it.t, k) : 0;
                        for (int p = 0; p < 4; p++) begin
                            c = coef_mem[store_addr(p, i, j, k, l)];
                            sum[p] = sat_add(sum[p], mul_round_sat(c,
                                     (p == POLY_PHI) ? mp : ma, DATA_FRAC,
                                     COEF_LO, COEF_HI));
                        end
                    end
        r.brho  = mul_round_sat(sum[0], cur_bref, REF_FRAC, COEF_LO, COEF_HI);
        r.theta = sum[1];
        r.phi   = sum[2];
        r.path  = sum[3];
        return r;
    endfunction

    // driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_result(drv_item));
            if (i_in_valid && !o_in_ready) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                drv_item = pending_items.pop_front();
                i_mode        <= drv_item.mode;
                i_coef_select <= drv_item.sel;
                i_pow_x       <= drv_item.px;
                i_pow_y       <= drv_item.py;
                i_pow_t       <= drv_item.pt;
                i_pow_p       <= drv_item.pp;
                i_coef_value  <= drv_item.coef;
                i_x_pos       <= drv_item.x;
                i_y_pos       <= drv_item.y;
                i_theta_in    <= drv_item.t;
                i_phi_in      <= drv_item.p;
                i_in_valid    <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    if (sender_gaps) gap_left = $urandom_range(1, 9);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        traj_result_t exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d", o_status);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status || o_brho !== exp_r.brho ||
                    o_theta_mrad !== exp_r.theta || o_phi_mrad !== exp_r.phi ||
                    o_path_cm !== exp_r.path) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st %0d brho %0d th %0d phi %0d path %0d",
                                 exp_r.status, exp_r.brho, exp_r.theta, exp_r.phi,
                                 exp_r.path);
                        $display("          got st %0d brho %0d th %0d phi %0d path %0d",
                                 o_status, o_brho, o_theta_mrad, o_phi_mrad, o_path_cm);
                    end
                end
            end
        end
        case (stall_style)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 2) != 0);
            2: i_out_ready <= (cycle_count % 7) > 2;
            default: i_out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return COEF_W'(COEF_HI);
            1: return COEF_W'(COEF_LO);
            2, 3: return $signed(r[COEF_W-1:0]) >>> $urandom_range(16, 30);
            default: return r[COEF_W-1:0];
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_point();
        case ($urandom_range(0, 7))
            0: return DATA_W'(DATA_HI);
            1: return DATA_W'(DATA_LO);
            2: return '0;
            3, 4, 5: return $signed($urandom) >>> 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic traj_item_t make_load(int sel, int px, int py, int pt, int pp,
                                             longint coef);
        traj_item_t it;
        it = '{mode: MODE_LOAD, sel: 2'(sel), px: POW_W'(px), py: POW_W'(py),
               pt: POW_W'(pt), pp: POW_W'(pp), coef: COEF_W'(coef),
               x: rand_point(), y: rand_point(), t: rand_point(), p: rand_point()};
        return it;
    endfunction

    function automatic traj_item_t make_recon(longint x, longint y, longint t, longint p);
        traj_item_t it;
        it = '{mode: MODE_RECON, sel: 2'($urandom_range(0, 3)),
               px: POW_W'($urandom_range(0, 7)), py: POW_W'($urandom_range(0, 7)),
               pt: POW_W'($urandom_range(0, 7)), pp: POW_W'($urandom_range(0, 7)),
               coef: rand_coef(), x: DATA_W'(x), y: DATA_W'(y), t: DATA_W'(t),
               p: DATA_W'(p)};
        return it;
    endfunction

    function automatic int rand_pow(int ord);
        return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(0, ord);
    endfunction

    task automatic cfg_write(logic idx, logic [BREF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ORDER) cur_order = val[ORDER_W-1:0];
        else                  cur_bref  = val;
    endtask

    // sample on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int orders [8] = '{7, 1, 4, 2, 7, 3, 5, 6};
        logic [BREF_W-1:0] brefs [8] = '{32'hFFFF_FFFF, 32'd0, 32'h0100_0000,
                                        32'h0080_0000, 32'h0280_0000, 32'h0000_0001,
                                        32'h1234_5678, 32'h00C0_0000};
        for (int n = 0; n < STORE_SIZE; n++) coef_mem[n] = 0;
        cur_order = ORDER_RESET;
        cur_bref  = BREF_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at full order with unit scale
        cfg_write(CFG_ORDER, 32'd7);
        cfg_write(CFG_BREF, BREF_RESET);
        pending_items.push_back(make_recon(DATA_HI, DATA_HI, DATA_HI, DATA_HI));
        for (int s = 0; s < 4; s++)
            pending_items.push_back(make_load(s, 0, 0, 0, 0, COEF_HI));
        pending_items.push_back(make_load(0, 7, 0, 0, 0, COEF_LO));
        pending_items.push_back(make_load(2, 0, 7, 0, 0, COEF_HI));
        pending_items.push_back(make_load(2, 0, 0, 0, 7, COEF_LO));
        pending_items.push_back(make_load(1, 1, 0, 6, 0, 48'sh0000_0100_0000));
        pending_items.push_back(make_load(3, 0, 0, 7, 0, -48'sh0000_0100_0000));
        pending_items.push_back(make_load(2, 7, 7, 7, 7, COEF_HI));
        pending_items.push_back(make_recon(DATA_HI, DATA_HI, DATA_HI, DATA_HI));
        pending_items.push_back(make_recon(DATA_LO, DATA_LO, DATA_LO, DATA_LO));
        pending_items.push_back(make_recon(0, 0, 0, 0));
        pending_items.push_back(make_recon(MONO_ONE, -MONO_ONE, MONO_ONE, -MONO_ONE));
        wait_drained();
        // directed: powers above a reduced order are dropped
        cfg_write(CFG_ORDER, 32'd3);
        cfg_write(CFG_BREF, 32'hFFFF_FFFF);
        pending_items.push_back(make_load(0, 4, 0, 0, 0, COEF_HI));
        pending_items.push_back(make_load(2, 0, 0, 0, 7, COEF_HI));
        pending_items.push_back(make_load(1, 3, 3, 3, 3, COEF_LO));
        pending_items.push_back(make_recon(MONO_ONE, MONO_ONE, MONO_ONE, MONO_ONE));
        pending_items.push_back(make_recon(DATA_LO, DATA_HI, DATA_LO, DATA_HI));
        wait_drained();
        // directed: order zero means not ready
        cfg_write(CFG_ORDER, 32'd0);
        pending_items.push_back(make_load(0, 0, 0, 0, 0, COEF_LO));
        pending_items.push_back(make_recon(DATA_HI, 0, 0, 0));
        pending_items.push_back(make_load(3, 7, 7, 7, 7, COEF_HI));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_ORDER, orders[ph]);
            cfg_write(CFG_BREF, (ph % 3 == 2) ? $urandom : brefs[ph]);
            sender_gaps = ph % 2;
            stall_style = ph % 4;
            for (int n = 0; n < 105; n++) begin
                if ($urandom_range(0, 9) < 7)
                    pending_items.push_back(make_load($urandom_range(0, 3),
                        rand_pow(orders[ph]), rand_pow(orders[ph]), rand_pow(orders[ph]),
                        rand_pow(orders[ph]), rand_coef()));
                else
                    pending_items.push_back(make_recon(rand_point(), rand_point(),
                        rand_point(), rand_point()));
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/tmpe_pkg.sv
rtl/tmpe_ram.sv
rtl/tmpe_lane.sv
rtl/transfer_matrix_poly_eval_core.sv
dv/tb_transfer_matrix_poly_eval_core.sv
